// ===== design/icm_pkg.sv =====
// icm_pkg: shared types and constants for the index of coincidence meter
// used by icm_divider and index_of_coincidence_meter; depends on nothing
`default_nettype none

package icm_pkg;

   // width of the q1.16 result, one integer bit so that 1.0 fits
   localparam int IC_W = 17;
   localparam logic [IC_W-1:0] IC_ONE = 17'h10000;

   localparam logic [7:0] NEWLINE_CODE = 8'd10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_PRODUCT,
      ST_START,
      ST_DIVIDE,
      ST_DONE
   } icm_state_type;

   typedef struct packed {
      logic            done;
      logic [IC_W-1:0] quotient;
   } icm_div_status_type;

endpackage

`default_nettype wire

// ===== design/icm_divider.sv =====
// icm_divider: restoring divider, one quotient bit per cycle, giving
// round(sum * 2^16 / den) as ((sum << 17) + den) / (2 * den); uses icm_pkg
`default_nettype none

module icm_divider import icm_pkg::*; #(
   parameter int SUM_W = 26
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [SUM_W-1:0] pair_sum,
   input  wire logic [SUM_W-1:0] denom,
   output icm_div_status_type    status
);

   localparam int STEP_W = $clog2(IC_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(IC_W - 1);

   logic [SUM_W:0]     rem_ff, rem_in;
   logic [SUM_W:0]     divisor_ff;
   logic [IC_W-1:0]    low_ff, quo_ff;
   logic [STEP_W-1:0]  step_ff;
   logic               busy_ff, done_ff;
   logic [SUM_W+1:0]   trial;
   logic               fits;

   // the quotient stays below 2^17, so the top part of the dividend
   // already sits below the divisor and only 17 steps are needed
   always_comb begin
      trial  = {rem_ff, low_ff[IC_W-1]};
      fits   = trial >= (SUM_W + 2)'(divisor_ff);
      rem_in = fits ? (SUM_W + 1)'(trial - (SUM_W + 2)'(divisor_ff))
                    : trial[SUM_W:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= busy_ff && (step_ff == LAST_STEP);
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + STEP_W'(1);
            if (step_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff     <= (SUM_W + 1)'(pair_sum) + (SUM_W + 1)'(denom >> IC_W);
         low_ff     <= IC_W'(denom);
         divisor_ff <= {denom, 1'b0};
         quo_ff     <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         low_ff <= {low_ff[IC_W-2:0], 1'b0};
         quo_ff <= {quo_ff[IC_W-2:0], fits};
      end
   end

   assign status.done     = done_ff;
   assign status.quotient = quo_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("divider did not start");

   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start |-> rem_ff < divisor_ff)
      else $error("partial remainder not below divisor");

   a_quo_range: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> quo_ff <= IC_ONE)
      else $error("quotient above one");

endmodule

`default_nettype wire

// ===== design/index_of_coincidence_meter.sv =====
// index_of_coincidence_meter: sampled byte histogram with running pair sum,
// index of coincidence in q1.16 on the last word; uses icm_pkg, icm_divider
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_stall   req_symbol, req_last
//   rsp_      out        rsp_valid / rsp_stall   rsp_ic_value, rsp_kept_count,
//                                                rsp_too_short, rsp_overflow
//   csr_      in         csr_wr_en               csr_wr_data (sample stride)
//
// skipped or dropped word: taken in idle; counted word: histogram read, write back
// last word then: product, divider load, 17 divide steps, done, hand-off,
// or product and hand-off only when fewer than two words were counted and no divide is needed
// reset is synchronous; histogram bins carry valid bits, so no clearing pass
// a waiting result does not block input; a new result waits while the held result is stalled
`default_nettype none

module index_of_coincidence_meter import icm_pkg::*; #(
   parameter int MAX_KEPT = 4096,
   parameter int ALPHABET = 256
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [7:0]                      req_symbol,
   input  wire logic                            req_last,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [IC_W-1:0]                      rsp_ic_value,
   output logic [$clog2(MAX_KEPT+1)-1:0]        rsp_kept_count,
   output logic                                 rsp_too_short,
   output logic                                 rsp_overflow,
   input  wire logic                            csr_wr_en,
   input  wire logic [7:0]                      csr_wr_data
);

   localparam int CW = $clog2(MAX_KEPT + 1);
   localparam int SW = 2 * CW;
   localparam int BW = $clog2(ALPHABET);

   icm_state_type      state_ff, state_in;
   icm_div_status_type div_status;

   logic [7:0]    stride_ff;
   logic [7:0]    skip_ff;
   logic [CW-1:0] kept_ff;
   logic [SW-1:0] pair_sum_ff;
   logic [SW-1:0] denom_ff;
   logic          overflow_ff;
   logic          last_ff;
   logic [BW-1:0] bin_ff;

   logic [CW-1:0]       hist_mem [ALPHABET];
   logic [CW-1:0]       rd_data_ff;
   logic [ALPHABET-1:0] bin_valid_ff;
   logic [BW-1:0]       bin_lut [256];

   logic          accept, keep, full, short_msg, slot_free;
   logic          hist_wr_en, div_start, rsp_load;
   logic [CW-1:0] freq;

   logic               rsp_valid_ff;
   logic [IC_W-1:0]    rsp_ic_ff;
   logic [CW-1:0]      rsp_kept_ff;
   logic               rsp_short_ff, rsp_ovf_ff;

   // symbol to bin, worked out at elaboration
   for (genvar g = 0; g < 256; g++) begin : g_bin
      assign bin_lut[g] = BW'(g % ALPHABET);
   end

   assign accept    = req_valid && !req_stall;
   assign keep      = skip_ff == 8'd0;
   assign full      = kept_ff == CW'(MAX_KEPT);
   assign short_msg = kept_ff < CW'(2);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign freq      = bin_valid_ff[bin_ff] ? rd_data_ff : '0;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (keep && !full) begin
                  state_in = ST_LOOKUP;
               end else if (req_last) begin
                  state_in = ST_PRODUCT;
               end
            end
         end
         ST_LOOKUP:  state_in = last_ff ? ST_PRODUCT : ST_IDLE;
         ST_PRODUCT: state_in = short_msg ? ST_DONE : ST_START;
         ST_START:   state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (div_status.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall  = state_ff != ST_IDLE;
      hist_wr_en = state_ff == ST_LOOKUP;
      div_start  = state_ff == ST_START;
      rsp_load   = (state_ff == ST_DONE) && slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stride_ff    <= 8'd1;
         skip_ff      <= '0;
         kept_ff      <= '0;
         pair_sum_ff  <= '0;
         overflow_ff  <= 1'b0;
         bin_valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            stride_ff <= csr_wr_data;
         end
         if (accept) begin
            if (keep) begin
               // a stride of zero behaves as one
               skip_ff <= (stride_ff == 8'd0) ? 8'd0 : stride_ff - 8'd1;
               if (full) begin
                  overflow_ff <= 1'b1;
               end
            end else if (req_symbol != NEWLINE_CODE) begin
               skip_ff <= skip_ff - 8'd1;
            end
         end
         if (hist_wr_en) begin
            bin_valid_ff[bin_ff] <= 1'b1;
            kept_ff              <= kept_ff + CW'(1);
            pair_sum_ff          <= pair_sum_ff + SW'({freq, 1'b0});
         end
         if (rsp_load) begin
            skip_ff      <= '0;
            kept_ff      <= '0;
            pair_sum_ff  <= '0;
            overflow_ff  <= 1'b0;
            bin_valid_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         bin_ff  <= bin_lut[req_symbol];
         last_ff <= req_last;
      end
      if (state_ff == ST_PRODUCT) begin
         denom_ff <= SW'(kept_ff * (kept_ff - CW'(1)));
      end
   end

   // histogram store, read on the accept cycle, written back in the cycle after it
   always_ff @(posedge clock) begin
      rd_data_ff <= hist_mem[bin_lut[req_symbol]];
      if (hist_wr_en) begin
         hist_mem[bin_ff] <= freq + CW'(1);
      end
   end

   icm_divider #(
      .SUM_W (SW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .pair_sum (pair_sum_ff),
      .denom    (denom_ff),
      .status   (div_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ic_ff    <= short_msg ? '0 : div_status.quotient;
         rsp_kept_ff  <= kept_ff;
         rsp_short_ff <= short_msg;
         rsp_ovf_ff   <= overflow_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ic_value   = rsp_ic_ff;
   assign rsp_kept_count = rsp_kept_ff;
   assign rsp_too_short  = rsp_short_ff;
   assign rsp_overflow   = rsp_ovf_ff;

   a_kept_cap: assert property (@(posedge clock) disable iff (reset)
      kept_ff <= CW'(MAX_KEPT))
      else $error("kept count above capacity");

   a_short_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_short_ff |-> rsp_ic_ff == '0)
      else $error("short message with nonzero value");

   a_ic_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ic_ff <= IC_ONE)
      else $error("value above one");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the hand-off state");

endmodule

`default_nettype wire
